// ----- rtl/ttl_lru_attribute_cache_assert.svh -----
// assertion macros for the ttl lru attribute cache
`ifndef TTL_LRU_ATTRIBUTE_CACHE_ASSERT_SVH
`define TTL_LRU_ATTRIBUTE_CACHE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TLC_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define TLC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ----- rtl/tlc_pkg.sv -----
// shared types and constants for the ttl lru attribute cache
package tlc_pkg;

  localparam int ENTRIES_DEF   = 128;
  localparam int KEY_BITS_DEF  = 32;
  localparam int META_BITS_DEF = 32;
  localparam int TIME_W        = 32;
  localparam int CAP_W         = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 1;
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(100);
  localparam logic [TIME_W-1:0] AGE_RESET = TIME_W'(100);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'd0,
    CFG_MAX_AGE  = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    M_INSERT,
    M_TOUCH,
    M_DROP
  } mode_t;

endpackage

// ----- rtl/tlc_if.sv -----
// request and response channel interfaces
interface tlc_req_if #(
  parameter int KEY_BITS  = 32,
  parameter int META_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [KEY_BITS-1:0]  handle_key;
  logic [META_BITS-1:0] meta_in;
  logic [31:0]          now;
  modport source (output valid, operation, handle_key, meta_in, now, input ready);
  modport sink (input valid, operation, handle_key, meta_in, now, output ready);
endinterface

interface tlc_rsp_if #(
  parameter int META_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [META_BITS-1:0] meta_out;
  modport source (output valid, status, meta_out, input ready);
  modport sink (input valid, status, meta_out, output ready);
endinterface

// ----- rtl/ttl_lru_attribute_cache.sv -----
// top level of the ttl lru attribute cache
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-----------------------------------------
//  req     | in  | valid / ready  | operation, handle_key, meta_in, now
//  rsp     | out | valid / ready  | status, meta_out
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
//  one item at a time; a search sweep reads over all entries in turn
//  an insert of a new key, a lookup hit or a remove hit adds an update sweep
//  over all entries, so an item takes one or two sweeps
//  the sweeps follow from the single read port of the entry and rank memories
//  rst clears the valid bits and the entry count and loads the config registers with their reset values
//  a new item is taken while a finished result still waits in the output register
module ttl_lru_attribute_cache
  import tlc_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int META_BITS = META_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tlc_req_if.sink               req,
  tlc_rsp_if.source             rsp
);

`include "ttl_lru_attribute_cache_assert.svh"

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENT_W  = KEY_BITS + META_BITS + TIME_W;

  // config registers
  logic [CAP_W-1:0]  capacity_limit;
  logic [TIME_W-1:0] max_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
      max_age        <= AGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CAPACITY: capacity_limit <= cfg_data[CAP_W-1:0];
        CFG_MAX_AGE:  max_age        <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // memories: entry word is {key, meta, stamp}, plus recency ranks
  logic [ENT_W-1:0]  ent_mem [ENTRIES];
  logic [RANK_W-1:0] rank_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_bits;

  state_t state, state_next;
  mode_t  mode;
  logic [CNT_W-1:0] count;

  // captured item
  op_t                  op;
  logic [KEY_BITS-1:0]  key;
  logic [META_BITS-1:0] meta;
  logic [TIME_W-1:0]    stamp_now;

  // insert eviction setup, taken at accept
  logic             evicting;
  logic [CNT_W-1:0] keep;

  // sweep control
  logic [RANK_W-1:0] addr;
  logic              issued_all;
  logic              rd_vld;
  logic [RANK_W-1:0] rd_idx;
  logic [ENT_W-1:0]  ent_q;
  logic [RANK_W-1:0] rank_q;

  // search results
  logic                 hit_found;
  logic [RANK_W-1:0]    hit_idx;
  logic [RANK_W-1:0]    hit_rank;
  logic [META_BITS-1:0] hit_meta;
  logic [TIME_W-1:0]    hit_stamp;
  logic                 slot_found;
  logic [RANK_W-1:0]    slot_idx;

  // result
  status_t              status_q;
  logic [META_BITS-1:0] meta_res;
  logic                 rsp_valid;
  logic [1:0]           rsp_status;
  logic [META_BITS-1:0] rsp_meta;

  logic accept;
  logic sweep_end;
  logic cur_valid;
  logic cur_evict;
  logic expired;
  logic [LIM_W-1:0] lim_raw;
  logic [CNT_W-1:0] lim;
  logic [KEY_BITS-1:0]  q_key;
  logic [META_BITS-1:0] q_meta;
  logic [TIME_W-1:0]    q_stamp;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign sweep_end = issued_all && !rd_vld;
  assign cur_valid = valid_bits[rd_idx];
  assign cur_evict = evicting && (CNT_W'(rank_q) >= keep);
  assign q_key     = ent_q[ENT_W-1 -: KEY_BITS];
  assign q_meta    = ent_q[TIME_W +: META_BITS];
  assign q_stamp   = ent_q[TIME_W-1:0];
  assign expired   = ({1'b0, hit_stamp} + {1'b0, max_age}) < {1'b0, stamp_now};

  // capacity clamp to 1 .. ENTRIES
  always_comb begin
    lim_raw = LIM_W'(capacity_limit);
    if (lim_raw == '0) begin
      lim = CNT_W'(1);
    end else if (lim_raw > LIM_W'(ENTRIES)) begin
      lim = CNT_W'(ENTRIES);
    end else begin
      lim = CNT_W'(lim_raw);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (sweep_end) begin
          priority if (op == OP_INSERT && !hit_found) state_next = S_UPDATE;
          else if ((op == OP_LOOKUP || op == OP_REMOVE) && hit_found) state_next = S_UPDATE;
          else state_next = S_RESP;
        end
      end
      S_UPDATE: begin
        if (sweep_end) state_next = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory ports: read at the sweep address, write back one behind
  logic              ent_we;
  logic              rank_we;
  logic [RANK_W-1:0] rank_wdata;

  always_ff @(posedge clk) begin
    ent_q  <= ent_mem[addr];
    rank_q <= rank_mem[addr];
    if (ent_we) ent_mem[rd_idx] <= {key, meta, stamp_now};
    if (rank_we) rank_mem[rd_idx] <= rank_wdata;
  end

  // read-modify-write decisions for the update sweep
  always_comb begin
    ent_we     = 1'b0;
    rank_we    = 1'b0;
    rank_wdata = '0;
    if (state == S_UPDATE && rd_vld) begin
      unique case (mode)
        M_INSERT: begin
          if (rd_idx == slot_idx) begin
            ent_we  = 1'b1;
            rank_we = 1'b1;
          end else if (cur_valid && !cur_evict) begin
            rank_we    = 1'b1;
            rank_wdata = rank_q + 1'b1;
          end
        end
        M_TOUCH: begin
          if (rd_idx == hit_idx) begin
            rank_we = 1'b1;
          end else if (cur_valid && rank_q < hit_rank) begin
            rank_we    = 1'b1;
            rank_wdata = rank_q + 1'b1;
          end
        end
        M_DROP: begin
          if (rd_idx == hit_idx) begin
            rank_we = 1'b1;
          end else if (cur_valid && rank_q > hit_rank) begin
            rank_we    = 1'b1;
            rank_wdata = rank_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      count      <= '0;
    end else begin
      if (state == S_UPDATE && rd_vld) begin
        unique case (mode)
          M_INSERT: begin
            if (rd_idx == slot_idx) valid_bits[rd_idx] <= 1'b1;
            else if (cur_evict) valid_bits[rd_idx] <= 1'b0;
          end
          M_DROP: begin
            if (rd_idx == hit_idx) valid_bits[rd_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
      // count is final once the update is decided
      if (state == S_SEARCH && sweep_end) begin
        if (op == OP_INSERT && !hit_found) begin
          count <= (evicting ? keep : count) + 1'b1;
        end else if (hit_found && (op == OP_REMOVE || (op == OP_LOOKUP && expired))) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // sweep address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld     <= 1'b0;
      issued_all <= 1'b1;
      addr       <= '0;
    end else begin
      if (accept || (state == S_SEARCH && sweep_end && state_next == S_UPDATE)) begin
        rd_vld     <= 1'b0;
        addr       <= '0;
        issued_all <= 1'b0;
      end else if ((state == S_SEARCH || state == S_UPDATE) && !issued_all) begin
        rd_vld <= 1'b1;
        if (addr == RANK_W'(ENTRIES - 1)) issued_all <= 1'b1;
        else addr <= addr + 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
      rd_idx <= addr;
    end
  end

  // item capture, search and decision
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= op_t'(req.operation);
      key        <= req.handle_key;
      meta       <= req.meta_in;
      stamp_now  <= req.now;
      evicting   <= (count >= lim);
      keep       <= lim - 1'b1;
      hit_found  <= 1'b0;
      slot_found <= 1'b0;
      hit_idx    <= '0;
      slot_idx   <= '0;
    end else if (state == S_SEARCH) begin
      if (rd_vld) begin
        if (cur_valid && q_key == key && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
          hit_rank  <= rank_q;
          hit_meta  <= q_meta;
          hit_stamp <= q_stamp;
        end
        if (!slot_found && (!cur_valid || cur_evict)) begin
          slot_found <= 1'b1;
          slot_idx   <= rd_idx;
        end
      end
      if (sweep_end) begin
        unique case (op)
          OP_INSERT: begin
            status_q <= hit_found ? ST_PRESENT : ST_DONE;
            mode     <= M_INSERT;
            meta_res <= '0;
          end
          OP_LOOKUP: begin
            if (hit_found && expired) begin
              status_q <= ST_EXPIRED;
              mode     <= M_DROP;
              meta_res <= '0;
            end else if (hit_found) begin
              status_q <= ST_DONE;
              mode     <= M_TOUCH;
              meta_res <= hit_meta;
            end else begin
              status_q <= ST_MISS;
              mode     <= M_INSERT;
              meta_res <= '0;
            end
          end
          OP_REMOVE: begin
            status_q <= hit_found ? ST_DONE : ST_MISS;
            mode     <= M_DROP;
            meta_res <= '0;
          end
          default: begin
            status_q <= ST_MISS;
            mode     <= M_INSERT;
            meta_res <= '0;
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_RESP && (!rsp_valid || rsp.ready)) begin
        rsp_valid  <= 1'b1;
        rsp_status <= status_q;
        rsp_meta   <= meta_res;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.meta_out = rsp_meta;

  `TLC_ASSERT_NEXT(a_accept_starts_search, clk, rst, accept, state == S_SEARCH)
  `TLC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(ENTRIES))
  `TLC_ASSERT_NOW(a_ent_write_insert_only, clk, rst, ent_we, mode == M_INSERT && rd_vld)
  `TLC_ASSERT_NOW(a_insert_has_slot, clk, rst,
    state == S_UPDATE && mode == M_INSERT, slot_found)

endmodule

// ----- bench/tb_ttl_lru_attribute_cache.sv -----
// testbench for the ttl lru attribute cache: directed and random items against an lru/ttl predictor
module tb_ttl_lru_attribute_cache;
  import tlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENT      = 128;
  localparam int LIMIT      = 3000000;
  localparam int DRAIN_WAIT = 2 * N_ENT + 40;

  typedef struct packed {
    status_t     status;
    logic [31:0] meta;
  } answer_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlc_req_if #(.KEY_BITS(32), .META_BITS(32)) req_ch ();
  tlc_rsp_if #(.META_BITS(32)) rsp_ch ();

  ttl_lru_attribute_cache dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  // shadow of the cache contents
  logic [7:0]  cap_reg;
  logic [31:0] age_reg;
  logic        ent_valid [N_ENT];
  logic [31:0] ent_key   [N_ENT];
  logic [31:0] ent_meta  [N_ENT];
  logic [31:0] ent_stamp [N_ENT];
  int          ent_rank  [N_ENT];
  int          ent_count;

  answer_t answers_due[$];
  int      mismatches;
  int      cycle_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic [31:0] now_tick;
  logic [31:0] key_pool[24];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int lookup_slot(logic [31:0] key);
    for (int i = 0; i < N_ENT; i++)
      if (ent_valid[i] && ent_key[i] == key) return i;
    return -1;
  endfunction

  // invalidate one slot, shift the ranks behind it down
  function automatic void drop_slot(int idx);
    int r;
    r = ent_rank[idx];
    for (int i = 0; i < N_ENT; i++)
      if (ent_valid[i] && ent_rank[i] > r) ent_rank[i]--;
    ent_valid[idx] = 1'b0;
    ent_rank[idx] = 0;
    if (ent_count > 0) ent_count--;
  endfunction

  function automatic void promote_slot(int idx);
    int r;
    r = ent_rank[idx];
    for (int i = 0; i < N_ENT; i++)
      if (ent_valid[i] && ent_rank[i] < r) ent_rank[i]++;
    ent_rank[idx] = 0;
  endfunction

  function automatic void evict_least_recent();
    int best;
    best = -1;
    for (int i = 0; i < N_ENT; i++)
      if (ent_valid[i] && (best < 0 || ent_rank[i] > ent_rank[best])) best = i;
    if (best >= 0) drop_slot(best);
  endfunction

  function automatic answer_t cache_outcome(op_t op, logic [31:0] key, logic [31:0] meta,
                                            logic [31:0] now);
    answer_t a;
    int idx;
    int lim;
    int fr;
    a.status = ST_MISS;
    a.meta = '0;
    idx = lookup_slot(key);
    case (op)
      OP_INSERT: begin
        if (idx >= 0) begin
          a.status = ST_PRESENT;
        end else begin
          // capacity 0 acts as 1, anything above the table size as the table size
          lim = (cap_reg == 0) ? 1 : ((cap_reg > N_ENT) ? N_ENT : int'(cap_reg));
          while (ent_count > 0 && ent_count >= lim) evict_least_recent();
          fr = -1;
          for (int i = 0; i < N_ENT; i++)
            if (fr < 0 && !ent_valid[i]) fr = i;
          if (fr >= 0) begin
            for (int j = 0; j < N_ENT; j++)
              if (ent_valid[j]) ent_rank[j]++;
            ent_valid[fr] = 1'b1;
            ent_key[fr]   = key;
            ent_meta[fr]  = meta;
            ent_stamp[fr] = now;
            ent_rank[fr]  = 0;
            ent_count++;
          end
          a.status = ST_DONE;
        end
      end
      OP_LOOKUP: begin
        if (idx >= 0) begin
          // age test done at 33 bits so the sum never wraps
          if ({1'b0, ent_stamp[idx]} + {1'b0, age_reg} < {1'b0, now}) begin
            drop_slot(idx);
            a.status = ST_EXPIRED;
          end else begin
            promote_slot(idx);
            a.status = ST_DONE;
            a.meta = ent_meta[idx];
          end
        end
      end
      OP_REMOVE: begin
        if (idx >= 0) begin
          drop_slot(idx);
          a.status = ST_DONE;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d meta %h", rsp_ch.status, rsp_ch.meta_out);
        end else begin
          want = answers_due.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.meta_out !== want.meta) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d meta %h, got status %0d meta %h",
                       want.status, want.meta, rsp_ch.status, rsp_ch.meta_out);
          end
        end
      end
    end
    // receiver backpressure, always ready when the stall rate is zero
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving helpers
  // send one item and record what it should return once it is accepted
  task automatic send_item(op_t op, logic [31:0] key, logic [31:0] meta, logic [31:0] now);
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.handle_key <= key;
    req_ch.meta_in    <= meta;
    req_ch.now        <= now;
    do @(posedge clk); while (!req_ch.ready);
    answers_due.push_back(cache_outcome(op, key, meta, now));
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write, only with the cache idle
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = value[7:0];
    else age_reg = value;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    write_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0, 32'h0, 32'h0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0, 32'h1234_5678, 32'hFFFF_FFFF);  // no wrap in the age sum
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0, 32'hAAAA_5555, 32'h5);           // already present
    send_item(OP_LOOKUP, 32'h5555_AAAA, 32'h0, 32'h5);           // miss
    send_item(OP_REMOVE, 32'h0, 32'h0, 32'h5);
    send_item(OP_REMOVE, 32'h0, 32'h0, 32'h5);                   // remove of absent key
    send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7);     // unused code
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h7);
  endtask

  task automatic test_expiry_boundary();
    write_reg(CFG_MAX_AGE, 32'd10);
    send_item(OP_INSERT, 32'hC0DE_0001, 32'h0BAD_F00D, 32'd100);
    send_item(OP_LOOKUP, 32'hC0DE_0001, 32'h0, 32'd110);  // exactly at the edge, still alive
    send_item(OP_LOOKUP, 32'hC0DE_0001, 32'h0, 32'd111);  // one past, dropped
    send_item(OP_LOOKUP, 32'hC0DE_0001, 32'h0, 32'd111);  // gone
    write_reg(CFG_MAX_AGE, 32'd0);
    send_item(OP_INSERT, 32'hC0DE_0002, 32'h1, 32'd50);
    send_item(OP_LOOKUP, 32'hC0DE_0002, 32'h0, 32'd50);
    send_item(OP_LOOKUP, 32'hC0DE_0002, 32'h0, 32'd51);
  endtask

  task automatic test_capacity_eviction();
    write_reg(CFG_MAX_AGE, 32'd1000);
    write_reg(CFG_CAPACITY, 32'd2);
    for (int k = 1; k <= 3; k++) send_item(OP_INSERT, 32'hE000_0000 + k, 32'(k), 32'd200);
    send_item(OP_LOOKUP, 32'hE000_0001, 32'h0, 32'd201);  // evicted
    send_item(OP_LOOKUP, 32'hE000_0002, 32'h0, 32'd201);
    write_reg(CFG_CAPACITY, 32'd8);
    for (int k = 0; k < 8; k++) send_item(OP_INSERT, 32'hF000_0000 + k, 32'(k), 32'd300);
    // capacity lowered below the count
    write_reg(CFG_CAPACITY, 32'hABCD_0003);  // upper bits ignored
    send_item(OP_LOOKUP, 32'hF000_0002, 32'h0, 32'd301);
    send_item(OP_INSERT, 32'hF000_0100, 32'h99, 32'd302);
    for (int k = 0; k < 8; k++) send_item(OP_LOOKUP, 32'hF000_0000 + k, 32'h0, 32'd303);
  endtask

  // random items over a small key pool so hits, expiries and evictions all happen
  task automatic test_random_phase(int count, logic [31:0] cap, logic [31:0] age,
                                   int idle_pct, int stall_pct);
    int pick;
    op_t op;
    logic [31:0] key;
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_MAX_AGE, age);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    now_tick = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      op = (pick < 42) ? OP_INSERT : (pick < 82) ? OP_LOOKUP : (pick < 96) ? OP_REMOVE : OP_NONE;
      key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(23)] : $urandom;
      if ($urandom_range(99) < 3) now_tick = $urandom;
      else now_tick = now_tick + $urandom_range(0, 12);
      send_item(op, key, $urandom, now_tick);
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_CAPACITY;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.operation  <= OP_INSERT;
    req_ch.handle_key <= '0;
    req_ch.meta_in    <= '0;
    req_ch.now        <= '0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cap_reg        = CAP_RESET;
    age_reg        = AGE_RESET;
    ent_count      = 0;
    for (int i = 0; i < N_ENT; i++) begin
      ent_valid[i] = 1'b0;
      ent_rank[i]  = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_expiry_boundary();
    test_capacity_eviction();
    test_random_phase(200, 32'd128, 32'd60, 0, 0);
    test_random_phase(200, 32'd1, 32'd40, 57, 0);
    test_random_phase(200, 32'd0, 32'hFFFF_FFFF, 0, 57);
    test_random_phase(200, 32'd255, 32'd0, 29, 29);
    test_random_phase(200, 32'd12, 32'd80, 57, 57);
    test_random_phase(200, 32'($urandom_range(2, 20)), 32'($urandom_range(20, 150)), 0, 29);

    drain();
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
